// File: design/amb_pkg.sv
package amb_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned MACH_W     = 23;
  localparam int unsigned AREA_W     = 32;
  localparam int unsigned A216_W     = AREA_W + 8;
  localparam int unsigned SUP_STEPS  = 17;
  localparam int unsigned SUB_STEPS  = 10;
  localparam int unsigned MACH_UPPER = 100;
  localparam int unsigned NUM_STEPS  = (SUP_STEPS > SUB_STEPS) ? SUP_STEPS : SUB_STEPS;
  localparam int unsigned CNT_W      = $clog2(NUM_STEPS + 1);

  // Widths of the cubic side: s = 5 + M^2, then s^2 and s^3.
  localparam int unsigned MSQ_W = 2 * MACH_W;
  localparam int unsigned S_W   = MSQ_W + 1;
  localparam int unsigned S2_W  = 2 * S_W;
  localparam int unsigned LHS_W = A216_W + MACH_W;
  localparam int unsigned CMP_W = 144;

  localparam logic [MACH_W-1:0] MACH_ONE = MACH_W'(1) << FRAC_BITS;
  localparam logic [MACH_W-1:0] MACH_TOP = MACH_W'(MACH_UPPER) << FRAC_BITS;
  localparam logic [S_W-1:0]    FIVE_S   = S_W'(5) << (2 * FRAC_BITS);

  typedef struct packed {
    logic              sup;
    logic [CNT_W-1:0]  cnt;
    logic [A216_W-1:0] a216;
    logic [MACH_W-1:0] lo;
    logic [MACH_W-1:0] hi;
    logic [MACH_W-1:0] mid;
  } ctx_t;

endpackage

// File: design/amb_step.sv
module amb_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  amb_pkg::ctx_t ctx_i,
  output logic          vld_o,
  output amb_pkg::ctx_t ctx_o
);
  import amb_pkg::*;

  logic [8:0]        vld_q;
  ctx_t              c_q [9];
  logic [LHS_W-1:0]  lhs_q [3:8];
  logic [S_W-1:0]    s_q [3:5];
  logic [MSQ_W-1:0]  msq_q;
  logic [42:0]       lp0_q, lp1_q;
  logic [45:0]       hh_q;
  logic [46:0]       hl_q;
  logic [47:0]       ll_q;
  logic [S2_W-1:0]   s2_q;
  logic [47:0]       p_q [4][2];
  logic [119:0]      t0_q, t1_q;
  logic [CMP_W-1:0]  s3_q;

  logic [MACH_W:0]   sum_d;
  ctx_t              c1_d, c9_d;
  logic [95:0]       s2x;
  logic [47:0]       sx;
  logic [119:0]      t0_d, t1_d;
  logic [CMP_W-1:0]  lhs_x;
  logic              go_hi;

  always_comb begin
    sum_d = {1'b0, ctx_i.lo} + {1'b0, ctx_i.hi};
    c1_d = ctx_i;
    if (ctx_i.cnt != '0) begin
      c1_d.mid = sum_d[MACH_W:1];
    end
  end

  assign s2x = {2'b0, s2_q};
  assign sx  = {1'b0, s_q[5]};

  always_comb begin
    t0_d = '0;
    t1_d = '0;
    for (int i = 0; i < 4; i++) begin
      t0_d = t0_d + (120'(p_q[i][0]) << (24 * i));
      t1_d = t1_d + (120'(p_q[i][1]) << (24 * i));
    end
  end

  // The area side is scaled up so both sides of A*216*M vs (5+M^2)^3 share one scale.
  assign lhs_x = {17'b0, lhs_q[8], 64'b0};

  always_comb begin
    go_hi = c_q[7].sup ? (lhs_x < s3_q) : (lhs_x > s3_q);
    c9_d = c_q[7];
    if (c_q[7].cnt != '0) begin
      c9_d.cnt = c_q[7].cnt - CNT_W'(1);
      if (go_hi) begin
        c9_d.hi = c_q[7].mid;
      end else begin
        c9_d.lo = c_q[7].mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[7:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0] <= c1_d;
      for (int k = 1; k < 8; k++) begin
        c_q[k] <= c_q[k-1];
      end
      c_q[8] <= c9_d;

      msq_q <= c_q[0].mid * c_q[0].mid;
      lp0_q <= c_q[0].a216[19:0] * c_q[0].mid;
      lp1_q <= c_q[0].a216[39:20] * c_q[0].mid;

      s_q[3]   <= FIVE_S + S_W'(msq_q);
      lhs_q[3] <= LHS_W'(lp0_q) + (LHS_W'(lp1_q) << 20);

      hh_q <= s_q[3][46:24] * s_q[3][46:24];
      hl_q <= s_q[3][46:24] * s_q[3][23:0];
      ll_q <= s_q[3][23:0] * s_q[3][23:0];
      s_q[4] <= s_q[3];

      s2_q <= (S2_W'(hh_q) << 48) + (S2_W'(hl_q) << 25) + S2_W'(ll_q);
      s_q[5] <= s_q[4];

      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          p_q[i][j] <= s2x[24*i +: 24] * sx[24*j +: 24];
        end
      end

      t0_q <= t0_d;
      t1_q <= t1_d;
      s3_q <= CMP_W'(t0_q) + (CMP_W'(t1_q) << 24);

      for (int k = 4; k <= 8; k++) begin
        lhs_q[k] <= lhs_q[k-1];
      end
    end
  end

  assign vld_o = vld_q[8];
  assign ctx_o = c_q[8];

endmodule

// File: design/area_ratio_to_mach_bisection_top.sv
// Area ratio to Mach number solver (isentropic flow, gamma 1.4).
// Input request: branch_i (0 subsonic, 1 supersonic) and area_ratio_i (unsigned
// Q16.16), handshaken by in_valid_i / in_ready_o. Result: mach_o (Q7.16),
// handshaken by out_valid_o / out_ready_i, one result per request, in order.
// Every bisection halving is unrolled into a nine-stage pipeline step: midpoint,
// square, sum, square of s, sum, cube partial products, two adder levels, and a
// compare with bracket update. Seventeen steps are chained; subsonic requests
// simply stop moving their bracket after ten halvings.
// Results leave through the output register behind the 17 steps of nine
// stages. Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops;
// nothing is lost or repeated. Reset clears all valid bits, so the block comes
// up empty and ready.
module area_ratio_to_mach_bisection_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        branch_i,
  input  logic [amb_pkg::AREA_W-1:0]  area_ratio_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [amb_pkg::MACH_W-1:0]  mach_o
);
  import amb_pkg::*;

  logic              en;
  logic              vld [NUM_STEPS+1];
  ctx_t              ctx [NUM_STEPS+1];
  logic [A216_W-1:0] a_ext;
  logic              out_vld_q;
  logic [MACH_W-1:0] mach_q;

  assign en = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign a_ext = A216_W'(area_ratio_i);

  always_comb begin
    ctx[0].sup  = branch_i;
    ctx[0].cnt  = branch_i ? CNT_W'(SUP_STEPS) : CNT_W'(SUB_STEPS);
    ctx[0].a216 = (a_ext << 7) + (a_ext << 6) + (a_ext << 4) + (a_ext << 3);
    ctx[0].lo   = branch_i ? MACH_ONE : '0;
    ctx[0].hi   = branch_i ? MACH_TOP : MACH_ONE;
    ctx[0].mid  = '0;
  end
  assign vld[0] = in_valid_i;

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
    amb_step u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (vld[g]),
      .ctx_i (ctx[g]),
      .vld_o (vld[g+1]),
      .ctx_o (ctx[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[NUM_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mach_q <= ctx[NUM_STEPS].mid;
    end
  end

  assign out_valid_o = out_vld_q;
  assign mach_o      = mach_q;

endmodule
